>>> src/ftws_pkg.sv
// Package for the frame time window statistics block.
// Holds the sequencer state type and the fixed field widths and constants.
// No dependencies.
package ftws_pkg;

    localparam int TIME_W    = 24;
    localparam int HELD_W    = 8;
    localparam int FPS_W     = 28;
    localparam int VAR_W     = 46;
    localparam int FRAMES_W  = 32;
    localparam int OUT_W     = 192;

    localparam logic [TIME_W-1:0]   MIN_RESET = 24'd1000000;
    localparam logic [FPS_W-1:0]    FPS_SCALE = 28'd256000000;
    localparam logic [FPS_W-1:0]    FPS_MAX   = 28'hFFFFFFF;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 32'hFFFFFFFF;
    localparam logic [HELD_W-1:0]   HELD_MAX  = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SQN,
        ST_SQO,
        ST_UPD,
        ST_LM1,
        ST_M1,
        ST_LM2,
        ST_M2,
        ST_LDM,
        ST_DM,
        ST_LDF,
        ST_DF,
        ST_LDV,
        ST_DV,
        ST_DONE
    } t_state;

endpackage

>>> src/frame_time_window_stats.sv
// Top level of the frame time window statistics block.
// Sample ring memory, running sums, serial multiplier and divider, output register.
// Depends on ftws_pkg.

// Each accepted frame time is written into a ring of the last WINDOW samples (filling
// first, then replacing the oldest) and yields one result transfer with the sample
// count, truncated mean, Q8 frame rate, population variance, all-time min/max and a
// saturating frame count. A bit-serial shift-add multiplier forms the two variance products
// and a restoring divider all three quotients; the squares and the remaining products are
// combinational. An item occupies the block until its result is loaded into the output
// register, which waits on m_tready while it still holds an unread result. A finished result
// waits in the output register while the next item is taken in. Items are accepted one
// at a time; the ring memory needs no clearing.
module frame_time_window_stats #(
    parameter int WINDOW = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [23:0] frame_time_us
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ftws_pkg::OUT_W-1:0] m_tdata    // [7:0] samples_held, [31:8] mean_time_us,
                                                  // [59:32] average_fps_q8,
                                                  // [105:60] variance_us2,
                                                  // [129:106] min_time_us,
                                                  // [153:130] max_time_us,
                                                  // [185:154] frames_seen, rest zero
);
    import ftws_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = TIME_W + CNT_W;
    localparam int SQS_W  = 2 * TIME_W + CNT_W;
    localparam int VNUM_W = 2 * SUM_W;
    localparam int FPSN_W = CNT_W + FPS_W;
    localparam int DIV_W  = VNUM_W;
    localparam int DVS_W  = SUM_W;
    localparam int CTR_W  = $clog2(VNUM_W + 1);

    t_state r_state, n_state;

    // sample ring
    logic [TIME_W-1:0] r_mem [WINDOW];
    logic [TIME_W-1:0] r_rd_data;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_wr_addr;

    // window state
    logic [CNT_W-1:0]    r_filled;
    logic [IDX_W-1:0]    r_oldest;
    logic [SUM_W-1:0]    r_sum;
    logic [SQS_W-1:0]    r_sqsum;
    logic [TIME_W-1:0]   r_least;
    logic [TIME_W-1:0]   r_greatest;
    logic [FRAMES_W-1:0] r_frames;
    logic                w_full;

    // per-item working registers
    logic [TIME_W-1:0]   r_t;
    logic [TIME_W-1:0]   r_old;
    logic [2*TIME_W-1:0] r_sq_new;
    logic [2*TIME_W-1:0] r_sq_old;
    logic [TIME_W-1:0]   w_sq_in;

    // serial multiplier
    logic [VNUM_W-1:0] r_acc;
    logic [VNUM_W-1:0] r_mcand;
    logic [SUM_W-1:0]  r_mplier;
    logic [VNUM_W-1:0] r_prod_a;
    logic [VNUM_W-1:0] w_acc_next;

    // serial divider
    logic [DIV_W-1:0]  r_num;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DVS_W-1:0]  w_rem_next;
    logic [CTR_W-1:0]  r_cnt;
    logic              w_last;

    // results
    logic [TIME_W-1:0] r_mean;
    logic [FPS_W-1:0]  r_fps;
    logic [FPSN_W-1:0] w_fps_num;
    logic [FPSN_W-1:0] w_fps_q;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              w_out_load;
    logic [HELD_W-1:0] w_held;

    assign w_full  = (r_filled == CNT_W'(WINDOW));
    assign w_last  = (r_cnt == CTR_W'(1));
    assign w_sq_in = (r_state == ST_SQN) ? r_t : r_old;

    assign w_acc_next = r_mplier[0] ? (r_acc + r_mcand) : r_acc;

    assign w_rem_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_next = w_ge ? DVS_W'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[DVS_W-1:0];

    assign w_fps_num = FPSN_W'(r_filled) * FPSN_W'(FPS_SCALE);
    assign w_fps_q   = r_num[FPSN_W-1:0];
    assign w_held    = (r_filled > CNT_W'(HELD_MAX)) ? HELD_MAX : HELD_W'(r_filled);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_tvalid) n_state = ST_RD;
            ST_RD:   n_state = ST_SQN;
            ST_SQN:  n_state = ST_SQO;
            ST_SQO:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_LM1;
            ST_LM1:  n_state = ST_M1;
            ST_M1:   if (w_last) n_state = ST_LM2;
            ST_LM2:  n_state = ST_M2;
            ST_M2:   if (w_last) n_state = ST_LDM;
            ST_LDM:  n_state = ST_DM;
            ST_DM:   if (w_last) n_state = ST_LDF;
            ST_LDF:  n_state = ST_DF;
            ST_DF:   if (w_last) n_state = ST_LDV;
            ST_LDV:  n_state = ST_DV;
            ST_DV:   if (w_last) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || m_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = (r_state == ST_IDLE);
        w_mem_we   = (r_state == ST_UPD);
        w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_tready);
        w_wr_addr  = w_full ? r_oldest : r_filled[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_wr_addr] <= r_t;
        r_rd_data <= r_mem[r_oldest];
    end

    // window state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled   <= '0;
            r_oldest   <= '0;
            r_sum      <= '0;
            r_sqsum    <= '0;
            r_least    <= MIN_RESET;
            r_greatest <= '0;
            r_frames   <= '0;
        end else if (r_state == ST_UPD) begin
            r_sum   <= r_sum - SUM_W'(r_old) + SUM_W'(r_t);
            r_sqsum <= r_sqsum - SQS_W'(r_sq_old) + SQS_W'(r_sq_new);
            if (w_full) begin
                r_oldest <= (r_oldest == IDX_W'(WINDOW - 1)) ? '0 : r_oldest + 1'b1;
            end else begin
                r_filled <= r_filled + 1'b1;
            end
            if (r_t < r_least)    r_least    <= r_t;
            if (r_t > r_greatest) r_greatest <= r_t;
            if (r_frames != FRAMES_MAX) r_frames <= r_frames + 1'b1;
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (s_tvalid) r_t <= s_tdata;
            ST_RD:   r_old <= w_full ? r_rd_data : '0;
            ST_SQN:  r_sq_new <= (2*TIME_W)'(w_sq_in) * (2*TIME_W)'(w_sq_in);
            ST_SQO:  r_sq_old <= (2*TIME_W)'(w_sq_in) * (2*TIME_W)'(w_sq_in);
            ST_LM1: begin
                r_acc    <= '0;
                r_mcand  <= VNUM_W'(r_sqsum);
                r_mplier <= SUM_W'(r_filled);
                r_cnt    <= CTR_W'(CNT_W);
            end
            ST_LM2: begin
                r_prod_a <= r_acc;
                r_acc    <= '0;
                r_mcand  <= VNUM_W'(r_sum);
                r_mplier <= r_sum;
                r_cnt    <= CTR_W'(SUM_W);
            end
            ST_M1, ST_M2: begin
                r_acc    <= w_acc_next;
                r_mcand  <= {r_mcand[VNUM_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SUM_W-1:1]};
                r_cnt    <= r_cnt - 1'b1;
            end
            ST_LDM: begin
                r_num <= {r_sum, {(DIV_W-SUM_W){1'b0}}};
                r_rem <= '0;
                r_dvs <= DVS_W'(r_filled);
                r_cnt <= CTR_W'(SUM_W);
            end
            ST_LDF: begin
                r_mean <= r_num[TIME_W-1:0];
                r_num  <= {w_fps_num, {(DIV_W-FPSN_W){1'b0}}};
                r_rem  <= '0;
                r_dvs  <= r_sum;
                r_cnt  <= CTR_W'(FPSN_W);
            end
            ST_LDV: begin
                // sum zero or quotient too large saturates
                if ((r_sum == '0) || (w_fps_q > FPSN_W'(FPS_MAX))) r_fps <= FPS_MAX;
                else                                               r_fps <= w_fps_q[FPS_W-1:0];
                r_num <= (r_prod_a >= r_acc) ? (r_prod_a - r_acc) : '0;
                r_rem <= '0;
                r_dvs <= DVS_W'(r_filled) * DVS_W'(r_filled);
                r_cnt <= CTR_W'(VNUM_W);
            end
            ST_DM, ST_DF, ST_DV: begin
                r_rem <= w_rem_next;
                r_num <= {r_num[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {6'd0, r_frames, r_greatest, r_least, r_num[VAR_W-1:0],
                           r_fps, r_mean, w_held};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(WINDOW))
        else $error("fill count above window depth");

    // replacement pointer only moves once the ring is full
    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> r_oldest == '0)
        else $error("oldest slot moved before ring full");

    // an accepted transfer starts the memory read
    a_accept_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_state == ST_RD)
        else $error("accepted item did not start read");

    // results appear only from the final sequencer step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> r_state == ST_DONE)
        else $error("result loaded outside done step");

    // minimum never rises above its start value
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_least <= MIN_RESET)
        else $error("minimum above start value");
`endif

endmodule
